### hdl/ssl_pkg.sv
// package: shared types and constants for the step scale to limits block
`timescale 1ns / 1ps
package ssl_pkg;

  localparam int FIELD_W = 32;           // width of the knob fields on the ports
  localparam int SUM_W   = FIELD_W + 1;  // sums and differences of two fields
  localparam int QUO_W   = 31;           // fraction bits of the Q1.31 scale
  localparam int SCALE_W = QUO_W + 1;
  localparam int LIM_W   = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [SCALE_W-1:0] SCALE_ONE = {1'b1, {QUO_W{1'b0}}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_ENABLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_ENABLE   = 2'd3;

  // limit mode codes
  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_MAGNITUDE = 2'd1;
  localparam logic [1:0] MODE_BOUNDS    = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;  // acts as no clamping

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_DECIDE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### hdl/ssl_if.sv
// interfaces: knob input channel and scale result channel
`timescale 1ns / 1ps
interface ssl_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssl_pkg::FIELD_W-1:0] knob_value;
  logic signed [ssl_pkg::FIELD_W-1:0] knob_step;
  logic signed [ssl_pkg::FIELD_W-1:0] lower_bound;
  logic signed [ssl_pkg::FIELD_W-1:0] upper_bound;
  logic                               last_knob;

  modport source (
    output valid, knob_value, knob_step, lower_bound, upper_bound, last_knob,
    input  ready
  );
  modport sink (
    input  valid, knob_value, knob_step, lower_bound, upper_bound, last_knob,
    output ready
  );
endinterface

interface ssl_out_if;
  logic                               valid;
  logic                               ready;
  logic        [ssl_pkg::SCALE_W-1:0] step_scale;
  logic                               blocked;

  modport source (
    output valid, step_scale, blocked,
    input  ready
  );
  modport sink (
    input  valid, step_scale, blocked,
    output ready
  );
endinterface

### hdl/ssl_div.sv
// iterative restoring divider: Q0.31 quotient of dividend/divisor, dividend < divisor
`timescale 1ns / 1ps
module ssl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssl_pkg::div_ctl_t             ctl,
  input  logic [ssl_pkg::FIELD_W-1:0]   dividend,
  input  logic [ssl_pkg::FIELD_W-1:0]   divisor,
  output ssl_pkg::div_sts_t             sts,
  output logic [ssl_pkg::QUO_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(ssl_pkg::QUO_W);

  logic [ssl_pkg::FIELD_W-1:0] rem_r;
  logic [ssl_pkg::FIELD_W-1:0] den_r;
  logic [ssl_pkg::QUO_W-1:0]   quo_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [ssl_pkg::FIELD_W:0]   rem2;
  logic [ssl_pkg::FIELD_W:0]   diff;
  logic                        fits;

  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, den_r};
  assign fits = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ssl_pkg::QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, msb first
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= dividend;
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[ssl_pkg::FIELD_W-1:0] : rem2[ssl_pkg::FIELD_W-1:0];
      quo_r <= {quo_r[ssl_pkg::QUO_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

### hdl/step_scale_to_limits_core.sv
// top level: running minimum step scale over a set of knobs
//
//  channel   dir  payload                                              handshake
//  in_ch     in   knob_value, knob_step, lower_bound, upper_bound,     valid/ready
//                 last_knob
//  out_ch    out  step_scale, blocked                                  valid/ready
//  cfg_*     in   cfg_index, cfg_data                                  cfg_we, no wait
//
// a knob passes sum, check, decide and finish when it sets no ratio or its ratio is 0 or
// 1.0, and also divide for the 31 quotient steps; in_ch.ready is high only while idle
// one result is held in the output register; a last knob waits in its final cycle while
// an earlier result is still untaken
// reset clears the configuration registers, the state, the output valid and the running minimum (1.0); no clearing pass
`timescale 1ns / 1ps
module step_scale_to_limits_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssl_in_if.sink                          in_ch,
  ssl_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FW = ssl_pkg::FIELD_W;
  localparam int SW = ssl_pkg::SUM_W;
  localparam int EXT_W = (VALUE_WIDTH > FW) ? FW : ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);
  localparam int EXT_SH = FW - EXT_W;

  function automatic logic signed [FW-1:0] sext(input logic [FW-1:0] x);
    logic signed [FW-1:0] t;
    t = $signed(x << EXT_SH);
    return t >>> EXT_SH;
  endfunction

  // configuration registers
  logic [1:0]                 limit_mode_r;
  logic [ssl_pkg::LIM_W-1:0]  strength_limit_r;
  logic                       lower_enable_r;
  logic                       upper_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r     <= ssl_pkg::MODE_NONE;
      strength_limit_r <= '0;
      lower_enable_r   <= 1'b0;
      upper_enable_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssl_pkg::REG_LIMIT_MODE:     limit_mode_r     <= cfg_data[1:0];
        ssl_pkg::REG_STRENGTH_LIMIT: strength_limit_r <= cfg_data[ssl_pkg::LIM_W-1:0];
        ssl_pkg::REG_LOWER_ENABLE:   lower_enable_r   <= cfg_data[0];
        ssl_pkg::REG_UPPER_ENABLE:   upper_enable_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  ssl_pkg::state_t state_r, state_nxt;

  logic signed [FW-1:0]       k0_r, dk_r, lo_r, hi_r;
  logic                       last_r;
  logic signed [SW-1:0]       k1_r, num_r;
  logic                       need_r, zero_r, take_r;
  logic [SW-1:0]              an_r;
  logic [FW-1:0]              ad_r;
  logic [ssl_pkg::SCALE_W-1:0] cand_r, run_min_r;
  logic                       out_valid_r;
  logic [ssl_pkg::SCALE_W-1:0] out_scale_r;
  logic                       out_blocked_r;

  ssl_pkg::div_ctl_t          div_ctl;
  ssl_pkg::div_sts_t          div_sts;
  logic [ssl_pkg::QUO_W-1:0]  div_quo;

  logic                       accept;
  logic                       out_free;
  logic                       emit;

  // sum stage
  logic signed [SW-1:0]       k1_sum, num_hi, num_lo, num_lim, target;
  // check stage
  logic [SW-1:0]              k1_mag, num_mag;
  logic [FW-1:0]              dk_mag;
  logic                       dk_zero, dk_neg, need_mag, need_bnd;
  // finish stage
  logic [ssl_pkg::SCALE_W-1:0] fin_scale;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = (state_r == ssl_pkg::ST_FINISH) && last_r && out_free;

  assign dk_zero = (dk_r == '0);
  assign dk_neg  = dk_r[FW-1];

  assign k1_sum  = SW'(k0_r) + SW'(dk_r);
  assign num_hi  = SW'(hi_r) - SW'(k0_r);
  assign num_lo  = SW'(lo_r) - SW'(k0_r);
  assign target  = dk_neg ? -$signed({2'b00, strength_limit_r})
                          : $signed({2'b00, strength_limit_r});
  assign num_lim = target - SW'(k0_r);

  assign k1_mag  = k1_r[SW-1] ? SW'(-k1_r) : SW'(k1_r);
  assign num_mag = num_r[SW-1] ? SW'(-num_r) : SW'(num_r);
  assign dk_mag  = dk_neg ? FW'(-dk_r) : FW'(dk_r);

  assign need_mag = (limit_mode_r == ssl_pkg::MODE_MAGNITUDE) && (strength_limit_r != '0)
                    && !dk_zero && (k1_mag > {2'b00, strength_limit_r});
  assign need_bnd = (limit_mode_r == ssl_pkg::MODE_BOUNDS) && !dk_zero
                    && ((upper_enable_r && !dk_neg && (k1_r > SW'(hi_r)))
                     || (lower_enable_r && dk_neg && (k1_r < SW'(lo_r))));

  assign fin_scale = (take_r && (cand_r < run_min_r)) ? cand_r : run_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_ctl.start = 1'b0;
    case (state_r)
      ssl_pkg::ST_IDLE: begin
        if (accept) state_nxt = ssl_pkg::ST_SUM;
      end
      ssl_pkg::ST_SUM:   state_nxt = ssl_pkg::ST_CHECK;
      ssl_pkg::ST_CHECK: state_nxt = ssl_pkg::ST_DECIDE;
      ssl_pkg::ST_DECIDE: begin
        if (need_r && !zero_r && (an_r < {1'b0, ad_r})) begin
          div_ctl.start = 1'b1;
          state_nxt     = ssl_pkg::ST_DIV;
        end else begin
          state_nxt = ssl_pkg::ST_FINISH;
        end
      end
      ssl_pkg::ST_DIV: begin
        if (div_sts.done) state_nxt = ssl_pkg::ST_FINISH;
      end
      ssl_pkg::ST_FINISH: begin
        if (!last_r || out_free) state_nxt = ssl_pkg::ST_IDLE;
      end
      default: state_nxt = ssl_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      k0_r   <= sext(in_ch.knob_value);
      dk_r   <= sext(in_ch.knob_step);
      lo_r   <= sext(in_ch.lower_bound);
      hi_r   <= sext(in_ch.upper_bound);
      last_r <= in_ch.last_knob;
    end
    if (state_r == ssl_pkg::ST_SUM) begin
      k1_r  <= k1_sum;
      num_r <= (limit_mode_r == ssl_pkg::MODE_MAGNITUDE) ? num_lim
             : (dk_neg ? num_lo : num_hi);
    end
    if (state_r == ssl_pkg::ST_CHECK) begin
      need_r <= need_mag || need_bnd;
      // ratio is negative or zero: scale 0
      zero_r <= (num_r == '0) || (num_r[SW-1] != dk_neg);
      an_r   <= num_mag;
      ad_r   <= dk_mag;
    end
    if (state_r == ssl_pkg::ST_DECIDE) begin
      take_r <= need_r;
      cand_r <= zero_r ? '0 : ssl_pkg::SCALE_ONE;
    end
    if ((state_r == ssl_pkg::ST_DIV) && div_sts.done) begin
      cand_r <= {1'b0, div_quo};
    end
    if (emit) begin
      out_scale_r   <= fin_scale;
      out_blocked_r <= (fin_scale == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r   <= ssl_pkg::SCALE_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        run_min_r   <= ssl_pkg::SCALE_ONE;
        out_valid_r <= 1'b1;
      end else begin
        if ((state_r == ssl_pkg::ST_FINISH) && !last_r) run_min_r <= fin_scale;
        if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      end
    end
  end

  ssl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (an_r[FW-1:0]),
    .divisor  (ad_r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign in_ch.ready       = (state_r == ssl_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.step_scale = out_scale_r;
  assign out_ch.blocked    = out_blocked_r;

  // checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ssl_pkg::ST_DIV))
    else $error("divider result outside the divide state");

  a_run_min_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    run_min_r <= ssl_pkg::SCALE_ONE)
    else $error("running minimum above 1.0");

  a_blocked_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_blocked_r == (out_scale_r == '0)))
    else $error("blocked flag does not match scale");

  a_emit_resets_min: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (run_min_r == ssl_pkg::SCALE_ONE) && out_valid_r)
    else $error("running minimum not restarted after a result");

endmodule

### test/ssl_scale_checker.sv
// checker: watches the knob and scale channels, predicts each scale and compares
`timescale 1ns / 1ps
module ssl_scale_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  ssl_in_if                              knob_mon,
  ssl_out_if                             scale_mon,
  input  logic                           cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_results
);

  typedef struct packed {
    logic [ssl_pkg::SCALE_W-1:0] scale;
    logic                        blocked;
  } scale_result_t;

  scale_result_t expected_scales[$];

  // shadow of the block's registers and running minimum
  logic [1:0]                  mode_q;
  logic [ssl_pkg::LIM_W-1:0]   limit_q;
  logic                        lower_en_q;
  logic                        upper_en_q;
  logic [ssl_pkg::SCALE_W-1:0] running_min;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Q1.31 of num/den truncated, clamped to [0, 1.0]
  function automatic logic [ssl_pkg::SCALE_W-1:0] knob_ratio(input longint num,
                                                              input longint den);
    longint unsigned mag_num;
    longint unsigned mag_den;
    longint unsigned quo;
    if (num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    mag_num = (num < 0) ? -num : num;
    mag_den = (den < 0) ? -den : den;
    if (mag_num >= mag_den) return ssl_pkg::SCALE_ONE;
    quo = (mag_num << ssl_pkg::QUO_W) / mag_den;
    return quo[ssl_pkg::SCALE_W-1:0];
  endfunction

  task automatic fold_ratio(input logic [ssl_pkg::SCALE_W-1:0] r);
    if (r < running_min) running_min = r;
  endtask

  task automatic predict_knob();
    longint k0;
    longint dk;
    longint lo;
    longint hi;
    longint k1;
    longint lim;
    longint mag;
    longint target;
    scale_result_t res;
    k0 = longint'(knob_mon.knob_value);
    dk = longint'(knob_mon.knob_step);
    lo = longint'(knob_mon.lower_bound);
    hi = longint'(knob_mon.upper_bound);
    k1 = k0 + dk;
    if (mode_q == ssl_pkg::MODE_MAGNITUDE && limit_q != 0 && dk != 0) begin
      lim = longint'(limit_q);
      mag = (k1 < 0) ? -k1 : k1;
      if (mag > lim) begin
        target = (dk > 0) ? lim : -lim;
        fold_ratio(knob_ratio(target - k0, dk));
      end
    end else if (mode_q == ssl_pkg::MODE_BOUNDS && dk != 0) begin
      if (upper_en_q && dk > 0 && k1 > hi) begin
        fold_ratio(knob_ratio(hi - k0, dk));
      end else if (lower_en_q && dk < 0 && k1 < lo) begin
        fold_ratio(knob_ratio(lo - k0, dk));
      end
    end
    if (knob_mon.last_knob) begin
      res.scale   = running_min;
      res.blocked = (running_min == '0);
      expected_scales.push_back(res);
      running_min = ssl_pkg::SCALE_ONE;
    end
  endtask

  always @(posedge clk) begin
    scale_result_t want;
    if (!rst_n) begin
      expected_scales.delete();
      mode_q      <= ssl_pkg::MODE_NONE;
      limit_q     <= '0;
      lower_en_q  <= 1'b0;
      upper_en_q  <= 1'b0;
      running_min = ssl_pkg::SCALE_ONE;
      fail_count  = 0;
    end else begin
      if (scale_mon.valid && scale_mon.ready) begin
        if (expected_scales.size() == 0) begin
          report_mismatch("unexpected scale transaction", scale_mon.step_scale, '0);
        end else begin
          want = expected_scales.pop_front();
          if (scale_mon.step_scale !== want.scale)
            report_mismatch("step_scale", scale_mon.step_scale, want.scale);
          if (scale_mon.blocked !== want.blocked)
            report_mismatch("blocked", 32'(scale_mon.blocked), 32'(want.blocked));
        end
      end
      // knob uses the registers in force before this edge's write
      if (knob_mon.valid && knob_mon.ready) predict_knob();
      if (cfg_we) begin
        case (cfg_index)
          ssl_pkg::REG_LIMIT_MODE:     mode_q     <= cfg_data[1:0];
          ssl_pkg::REG_STRENGTH_LIMIT: limit_q    <= cfg_data[ssl_pkg::LIM_W-1:0];
          ssl_pkg::REG_LOWER_ENABLE:   lower_en_q <= cfg_data[0];
          ssl_pkg::REG_UPPER_ENABLE:   upper_en_q <= cfg_data[0];
          default: ;
        endcase
      end
    end
    pending_results = expected_scales.size();
  end

endmodule

### test/tb_step_scale_to_limits_core.sv
// testbench top: clock, reset, knob stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module tb_step_scale_to_limits_core;

  localparam int SETTLE_CYCLES = 50;
  localparam int PHASE_ITEMS   = 220;
  localparam int IDX_W  = ssl_pkg::CFG_IDX_W;
  localparam int DATA_W = ssl_pkg::CFG_DATA_W;
  localparam int LIM_W  = ssl_pkg::LIM_W;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [DATA_W-1:0]     cfg_data;
  int                    fail_count;
  int                    pending_results;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned field_span;

  ssl_in_if  knob_ch ();
  ssl_out_if scale_ch ();

  step_scale_to_limits_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (knob_ch),
    .out_ch   (scale_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ssl_scale_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .knob_mon       (knob_ch),
    .scale_mon      (scale_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(64'd10_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // receiver side: ready decided at each falling edge
  initial begin
    scale_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      scale_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // called and returns just after a falling edge; valid is left high for the caller
  task automatic send_knob(input logic [31:0] value, input logic [31:0] step,
                           input logic [31:0] lo, input logic [31:0] hi, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      knob_ch.valid = 1'b0;
      @(negedge clk);
    end
    knob_ch.valid       = 1'b1;
    knob_ch.knob_value  = value;
    knob_ch.knob_step   = step;
    knob_ch.lower_bound = lo;
    knob_ch.upper_bound = hi;
    knob_ch.last_knob   = last;
    do @(posedge clk); while (!knob_ch.ready);
    @(negedge clk);
  endtask

  // drop valid, wait for every scale, then give the block time to finish a knob
  task automatic settle();
    knob_ch.valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // unused upper bits of the mode and enable writes carry random junk
  task automatic configure(input logic [1:0] mode, input logic [LIM_W-1:0] limit,
                           input logic lo_en, input logic up_en);
    logic [DATA_W-1:0] junk;
    junk = DATA_W'($urandom());
    write_reg(ssl_pkg::REG_LIMIT_MODE, {junk[DATA_W-1:2], mode});
    write_reg(ssl_pkg::REG_STRENGTH_LIMIT, limit);
    junk = DATA_W'($urandom());
    write_reg(ssl_pkg::REG_LOWER_ENABLE, {junk[DATA_W-1:1], lo_en});
    junk = DATA_W'($urandom());
    write_reg(ssl_pkg::REG_UPPER_ENABLE, {junk[DATA_W-1:1], up_en});
  endtask

  function automatic logic [31:0] pick_field(input int unsigned span);
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(4))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        3: v = 32'h0000_0001;
        default: v = 32'hffff_ffff;
      endcase
    end else if (r < 25) begin
      v = $urandom();
    end else begin
      v = $urandom_range(span);
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  task automatic send_random_knob(input logic last);
    logic [31:0] v;
    logic [31:0] s;
    logic [31:0] lo;
    logic [31:0] hi;
    v = pick_field(field_span);
    s = pick_field(field_span);
    if ($urandom_range(99) < 75) begin
      lo = v - $urandom_range(field_span);
      hi = v + $urandom_range(field_span);
    end else begin
      lo = pick_field(field_span);
      hi = pick_field(field_span);
    end
    send_knob(v, s, lo, hi, last);
  endtask

  task automatic set_idling(input int unsigned kind);
    case (kind)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
      default: begin src_idle_pct = 32; sink_stall_pct = 32; end
    endcase
  endtask

  initial begin
    int unsigned limit;
    int unsigned n;
    int unsigned items;
    longint unsigned wide_span;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    knob_ch.valid       = 1'b0;
    knob_ch.knob_value  = '0;
    knob_ch.knob_step   = '0;
    knob_ch.lower_bound = '0;
    knob_ch.upper_bound = '0;
    knob_ch.last_knob   = 1'b0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    field_span          = 32'h0008_0000;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // no clamping straight out of reset
    send_knob(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
    send_knob(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    settle();

    // magnitude mode with a zero limit leaves the scale at 1.0
    write_reg(ssl_pkg::REG_LIMIT_MODE, {{(DATA_W-2){1'b0}}, ssl_pkg::MODE_MAGNITUDE});
    send_knob(32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1);
    settle();

    write_reg(ssl_pkg::REG_STRENGTH_LIMIT, 31'h0001_0000);
    send_knob(32'h0000_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b0);
    send_knob(32'h0000_8000, -32'h0002_0000, 32'h0, 32'h0, 1'b0);
    send_knob(32'h0003_0000, 32'h0000_0000, 32'h0, 32'h0, 1'b1);   // zero step skipped
    send_knob(32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1);   // already past: blocked
    send_knob(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
    send_knob(32'h0000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
    send_knob(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1);
    send_knob(32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0, 1'b1);   // lands on the limit
    settle();

    write_reg(ssl_pkg::REG_STRENGTH_LIMIT, 31'h7fff_ffff);
    send_knob(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
    send_knob(32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h0, 1'b1);
    // registers change between two knobs of one set
    send_knob(32'h4000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
    settle();
    write_reg(ssl_pkg::REG_LIMIT_MODE, {{(DATA_W-2){1'b0}}, ssl_pkg::MODE_BOUNDS});
    write_reg(ssl_pkg::REG_UPPER_ENABLE, 31'h1);
    send_knob(32'h0000_0000, 32'h0002_0000, 32'h0, 32'h0001_0000, 1'b1);
    send_knob(32'h0000_0000, -32'h0002_0000, -32'h0001_0000, 32'h0, 1'b1);  // lower off
    settle();

    write_reg(ssl_pkg::REG_LOWER_ENABLE, 31'h1);
    send_knob(32'h0000_0000, -32'h0002_0000, -32'h0001_0000, 32'h0, 1'b1);
    send_knob(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, -32'h0001_0000, 1'b1);
    send_knob(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1);    // bound behind
    send_knob(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_knob(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    settle();

    // bounds mode with both sides off
    configure(ssl_pkg::MODE_BOUNDS, 31'h0001_0000, 1'b0, 1'b0);
    send_knob(32'h0000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
    settle();

    // the unused mode code behaves as no clamping
    configure(ssl_pkg::MODE_UNUSED, 31'h0001_0000, 1'b1, 1'b1);
    send_knob(32'h0000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 1'b1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      set_idling(phase % 4);
      case (phase)
        0: begin
          limit = $urandom_range(32'h0020_0000, 32'h0000_0100);
          configure(ssl_pkg::MODE_MAGNITUDE, LIM_W'(limit), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
        1: begin
          limit = 0;
          configure(ssl_pkg::MODE_BOUNDS, LIM_W'($urandom()), 1'b1, 1'b1);
        end
        2: begin
          limit = 0;
          configure(ssl_pkg::MODE_BOUNDS, LIM_W'($urandom()), 1'b1, 1'b0);
        end
        3: begin
          limit = 0;
          configure(ssl_pkg::MODE_BOUNDS, LIM_W'($urandom()), 1'b0, 1'b1);
        end
        4: begin
          limit = 32'h7fff_ffff;
          configure(ssl_pkg::MODE_MAGNITUDE, LIM_W'(limit), 1'b1, 1'b0);
        end
        5: begin
          limit = 1;
          configure(ssl_pkg::MODE_MAGNITUDE, LIM_W'(limit), 1'b0, 1'b1);
        end
        6: begin
          limit = 0;
          configure(ssl_pkg::MODE_NONE, LIM_W'($urandom()), 1'b1, 1'b1);
        end
        default: begin
          limit = 0;
          configure(ssl_pkg::MODE_UNUSED, LIM_W'($urandom()), 1'b1, 1'b1);
        end
      endcase
      if (limit != 0) begin
        wide_span = 64'(limit) * 3;
        field_span = (wide_span > 64'hffff_ffff) ? 32'hffff_ffff : wide_span[31:0];
      end else begin
        field_span = $urandom_range(32'h0100_0000, 32'h0000_1000);
      end
      items = 0;
      while (items < PHASE_ITEMS) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
        for (int i = 0; i < n; i++) send_random_knob(i == n - 1);
        items += n;
      end
      settle();
    end

    if (fail_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ssl_pkg.sv
hdl/ssl_if.sv
hdl/ssl_div.sv
hdl/step_scale_to_limits_core.sv
test/ssl_scale_checker.sv
test/tb_step_scale_to_limits_core.sv
